FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the trimmer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/rqt_pkg.sv
// Types, constants and helper functions of the read adapter and quality trimmer.
package rqt_pkg;

    localparam int ADAPTER_MAX = 64;
    localparam int READ_MAX    = 65536;

    localparam int AIDX_W = $clog2(ADAPTER_MAX);
    localparam int OVL_W  = $clog2(ADAPTER_MAX + 1);
    localparam int LEN_W  = $clog2(READ_MAX + 1);

    // Mismatch counters saturate one above the largest allowed mismatch count.
    localparam int MM_W = 5;
    localparam logic [MM_W-1:0] MISMATCH_CAP = 5'd16;

    localparam logic [7:0] QUAL_MIN      = 8'd33;
    localparam logic [7:0] QUAL_MAX      = 8'd126;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7a;
    localparam logic [7:0] CASE_DIFF     = 8'h20;

    localparam logic ACT_ADAPTER_WRITE = 1'b0;
    localparam logic ACT_BASE          = 1'b1;

    localparam logic [1:0] QCLASS_LOW  = 2'd0;
    localparam logic [1:0] QCLASS_GOOD = 2'd1;
    localparam logic [1:0] QCLASS_BAD  = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_QUALITY = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG    = 2'd2;

    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ADAPTER_LENGTH    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_OVERLAP       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_MISMATCHES    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_QUALITY_THRESHOLD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_LENGTH        = 3'd4;

    typedef struct packed {
        logic       action;
        logic [5:0] adapter_index;
        logic [7:0] base_byte;
        logic [7:0] quality_byte;
        logic       last_base;
    } item_t;

    typedef struct packed {
        logic [16:0] trimmed_length;
        logic [6:0]  adapter_cut;
        logic [16:0] quality_cut;
        logic        keep;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic [6:0]  adapter_length;
        logic [6:0]  min_overlap;
        logic [3:0]  max_mismatches;
        logic [5:0]  qual_threshold;
        logic [16:0] min_length;
    } cfg_t;

    // Snapshot of one read taken at its last base.
    typedef struct packed {
        logic                   too_long;
        logic [LEN_W-1:0]       len;
        logic [ADAPTER_MAX-1:0] hit;
        logic [ADAPTER_MAX-1:0] nz;
        logic [ADAPTER_MAX-1:0] bad;
        logic [LEN_W-1:0]       dec_pos;
        logic [1:0]             dec_kind;
    } job_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/rqt_cfg_regs.sv
// APB configuration registers of the trimmer.
module rqt_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rqt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output rqt_pkg::cfg_t             cfg
);

    rqt_pkg::cfg_t                    cfg_reg;
    logic [rqt_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[rqt_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adapter_length <= 7'd0;
            cfg_reg.min_overlap    <= 7'd3;
            cfg_reg.max_mismatches <= 4'd0;
            cfg_reg.qual_threshold <= 6'd0;
            cfg_reg.min_length     <= 17'd1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                rqt_pkg::REG_ADAPTER_LENGTH:    cfg_reg.adapter_length <= pwdata[6:0];
                rqt_pkg::REG_MIN_OVERLAP:       cfg_reg.min_overlap    <= pwdata[6:0];
                rqt_pkg::REG_MAX_MISMATCHES:    cfg_reg.max_mismatches <= pwdata[3:0];
                rqt_pkg::REG_QUALITY_THRESHOLD: cfg_reg.qual_threshold <= pwdata[5:0];
                rqt_pkg::REG_MIN_LENGTH:        cfg_reg.min_length     <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rqt_pkg::REG_ADAPTER_LENGTH:    prdata = {25'd0, cfg_reg.adapter_length};
            rqt_pkg::REG_MIN_OVERLAP:       prdata = {25'd0, cfg_reg.min_overlap};
            rqt_pkg::REG_MAX_MISMATCHES:    prdata = {28'd0, cfg_reg.max_mismatches};
            rqt_pkg::REG_QUALITY_THRESHOLD: prdata = {26'd0, cfg_reg.qual_threshold};
            rqt_pkg::REG_MIN_LENGTH:        prdata = {15'd0, cfg_reg.min_length};
            default:                        prdata = 32'd0;
        endcase
    end

endmodule

FILE: hw/rtl/rqt_scan.sv
// Per-base stage: adapter store, mismatch counters, quality window and read snapshot.
module rqt_scan (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  rqt_pkg::item_t  item,
    input  rqt_pkg::cfg_t   cfg,
    output logic            job_valid,
    output rqt_pkg::job_t   job,
    input  logic            job_stall
);

    localparam int AM    = rqt_pkg::ADAPTER_MAX;
    localparam int LEN_W = rqt_pkg::LEN_W;
    localparam int OVL_W = rqt_pkg::OVL_W;
    localparam int MM_W  = rqt_pkg::MM_W;

    logic                  in_valid_reg;
    rqt_pkg::item_t        in_reg;

    logic [7:0]            adapter_reg [AM];
    logic [MM_W-1:0]       mism_reg    [AM];
    logic [MM_W-1:0]       mism_next   [AM];
    logic [1:0]            qcls_reg    [AM];
    logic [1:0]            qcls_next   [AM];
    logic [AM-1:0]         mis;

    logic [LEN_W-1:0]      pos_reg, pos_next;
    logic [LEN_W-1:0]      dec_pos_reg, dec_pos_next;
    logic [1:0]            dec_kind_reg, dec_kind_next;
    logic                  too_long_reg, too_long_next;

    logic                  is_base, in_move, accept, too_long_now, take, shift_en;
    logic [7:0]            upper_base;
    logic [1:0]            cls;
    logic [LEN_W-1:0]      len_next;
    logic [LEN_W-1:0]      dec_pos_upd;
    logic [1:0]            dec_kind_upd;
    logic [OVL_W-1:0]      alen_eff, lo_eff;

    assign is_base    = in_reg.action == rqt_pkg::ACT_BASE;
    assign job_valid  = in_valid_reg && is_base && in_reg.last_base;
    assign in_move    = in_valid_reg && !(job_valid && job_stall);
    assign item_stall = in_valid_reg && !in_move;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
    end

    // The adapter store has no reset; entries used must first be written by the user.
    always_ff @(posedge clk)
    begin
        if (in_move && !is_base)
        begin
            adapter_reg[in_reg.adapter_index] <= in_reg.base_byte;
        end
    end

    assign upper_base   = rqt_pkg::to_upper(in_reg.base_byte);
    assign too_long_now = too_long_reg || (pos_reg >= LEN_W'(rqt_pkg::READ_MAX));
    assign take         = !too_long_now;
    assign shift_en     = in_move && is_base && take;
    assign len_next     = take ? pos_reg + LEN_W'(1) : pos_reg;
    assign alen_eff     = (cfg.adapter_length > OVL_W'(AM)) ? OVL_W'(AM) : cfg.adapter_length;
    assign lo_eff       = (cfg.min_overlap == '0) ? OVL_W'(1) : cfg.min_overlap;

    always_comb
    begin
        if (in_reg.quality_byte < rqt_pkg::QUAL_MIN || in_reg.quality_byte > rqt_pkg::QUAL_MAX)
        begin
            cls = rqt_pkg::QCLASS_BAD;
        end
        else if ((in_reg.quality_byte - rqt_pkg::QUAL_MIN) < {2'b00, cfg.qual_threshold})
        begin
            cls = rqt_pkg::QCLASS_LOW;
        end
        else
        begin
            cls = rqt_pkg::QCLASS_GOOD;
        end
    end

    // Counter k holds the mismatch count of the start k bases back from the newest base.
    always_comb
    begin
        for (int k = 0; k < AM; k++)
        begin
            mis[k] = upper_base != rqt_pkg::to_upper(adapter_reg[k]);
        end
        mism_next[0] = MM_W'(mis[0]);
        qcls_next[0] = cls;
        for (int k = 1; k < AM; k++)
        begin
            if (mism_reg[k-1] == rqt_pkg::MISMATCH_CAP)
            begin
                mism_next[k] = mism_reg[k-1];
            end
            else
            begin
                mism_next[k] = mism_reg[k-1] + MM_W'(mis[k]);
            end
            qcls_next[k] = qcls_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AM; k++)
            begin
                mism_reg[k] <= '0;
                qcls_reg[k] <= rqt_pkg::QCLASS_LOW;
            end
        end
        else if (shift_en)
        begin
            for (int k = 0; k < AM; k++)
            begin
                mism_reg[k] <= mism_next[k];
                qcls_reg[k] <= qcls_next[k];
            end
        end
    end

    // The oldest window entry leaves when a base arrives; a good or bad one becomes
    // the decider for scans that run past the window.
    always_comb
    begin
        dec_pos_upd  = dec_pos_reg;
        dec_kind_upd = dec_kind_reg;
        if (take && pos_reg >= LEN_W'(AM) && qcls_reg[AM-1] != rqt_pkg::QCLASS_LOW)
        begin
            dec_pos_upd  = pos_reg - LEN_W'(AM - 1);
            dec_kind_upd = qcls_reg[AM-1];
        end

        pos_next      = pos_reg;
        dec_pos_next  = dec_pos_reg;
        dec_kind_next = dec_kind_reg;
        too_long_next = too_long_reg;
        if (in_move && is_base)
        begin
            if (in_reg.last_base)
            begin
                pos_next      = '0;
                dec_pos_next  = '0;
                dec_kind_next = rqt_pkg::QCLASS_LOW;
                too_long_next = 1'b0;
            end
            else
            begin
                pos_next      = len_next;
                dec_pos_next  = dec_pos_upd;
                dec_kind_next = dec_kind_upd;
                too_long_next = too_long_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            dec_pos_reg  <= '0;
            dec_kind_reg <= rqt_pkg::QCLASS_LOW;
            too_long_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            dec_pos_reg  <= dec_pos_next;
            dec_kind_reg <= dec_kind_next;
            too_long_reg <= too_long_next;
        end
    end

    // Snapshot of the read as it stands after its last base; entry k is overlap k + 1.
    always_comb
    begin
        job.too_long = too_long_now;
        job.len      = len_next;
        job.dec_pos  = dec_pos_upd;
        job.dec_kind = dec_kind_upd;
        for (int k = 0; k < AM; k++)
        begin
            job.hit[k] = (mism_next[k] <= MM_W'(cfg.max_mismatches))
                         && (OVL_W'(k + 1) >= lo_eff)
                         && (OVL_W'(k + 1) <= alen_eff)
                         && (LEN_W'(k + 1) <= len_next);
            job.nz[k]  = (qcls_next[k] != rqt_pkg::QCLASS_LOW) && (LEN_W'(k) < len_next);
            job.bad[k] = qcls_next[k] == rqt_pkg::QCLASS_BAD;
        end
    end

endmodule

FILE: hw/rtl/rqt_finish.sv
// End-of-read stages: adapter hit selection, trailing quality scan and result register.
module rqt_finish (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_stall,
    input  rqt_pkg::job_t    job,
    input  rqt_pkg::cfg_t    cfg,
    output logic             result_valid,
    input  logic             result_stall,
    output rqt_pkg::result_t result
);

    localparam int AM     = rqt_pkg::ADAPTER_MAX;
    localparam int LEN_W  = rqt_pkg::LEN_W;
    localparam int OVL_W  = rqt_pkg::OVL_W;
    localparam int AIDX_W = rqt_pkg::AIDX_W;

    typedef struct packed {
        logic             too_long;
        logic [LEN_W-1:0] len;
        logic [OVL_W-1:0] o;
        logic [LEN_W-1:0] cut_pos;
        logic [AM-1:0]    nz;
        logic [AM-1:0]    bad;
        logic [LEN_W-1:0] dec_pos;
        logic [1:0]       dec_kind;
    } stage_t;

    logic              j_valid_reg, a_valid_reg, r_valid_reg;
    rqt_pkg::job_t     j_reg;
    stage_t            a_reg, a_next;
    rqt_pkg::result_t  r_reg, r_next;
    logic              j_move, a_move, r_free;

    logic [OVL_W-1:0]  o_sel;
    logic              found, found_bad, bad;
    logic [AIDX_W-1:0] k_sel;
    logic [LEN_W-1:0]  e;

    assign r_free    = !r_valid_reg || !result_stall;
    assign a_move    = a_valid_reg && r_free;
    assign j_move    = j_valid_reg && (!a_valid_reg || a_move);
    assign job_stall = j_valid_reg && !j_move;

    assign result_valid = r_valid_reg;
    assign result       = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid && !job_stall)
            begin
                j_valid_reg <= 1'b1;
            end
            else if (j_move)
            begin
                j_valid_reg <= 1'b0;
            end

            if (j_move)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_move)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (r_valid_reg && !result_stall)
            begin
                r_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && !job_stall)
        begin
            j_reg <= job;
        end
        if (j_move)
        begin
            a_reg <= a_next;
        end
        if (a_move)
        begin
            r_reg <= r_next;
        end
    end

    // The largest overlap that qualifies is the earliest adapter start.
    always_comb
    begin
        o_sel = '0;
        for (int k = 0; k < AM; k++)
        begin
            if (j_reg.hit[k])
            begin
                o_sel = OVL_W'(k + 1);
            end
        end
        a_next.too_long = j_reg.too_long;
        a_next.len      = j_reg.len;
        a_next.o        = o_sel;
        a_next.cut_pos  = j_reg.len - LEN_W'(o_sel);
        a_next.nz       = j_reg.nz;
        a_next.bad      = j_reg.bad;
        a_next.dec_pos  = j_reg.dec_pos;
        a_next.dec_kind = j_reg.dec_kind;
    end

    // Window entry k is base len - 1 - k; the scan starts just below the adapter cut.
    always_comb
    begin
        found     = 1'b0;
        found_bad = 1'b0;
        k_sel     = '0;
        for (int k = AM - 1; k >= 0; k--)
        begin
            if (a_reg.nz[k] && OVL_W'(k) >= a_reg.o)
            begin
                found     = 1'b1;
                found_bad = a_reg.bad[k];
                k_sel     = AIDX_W'(k);
            end
        end

        bad = 1'b0;
        e   = '0;
        if (found)
        begin
            bad = found_bad;
            e   = a_reg.len - LEN_W'(k_sel);
        end
        else if (a_reg.len > LEN_W'(AM) && a_reg.dec_pos != '0)
        begin
            if (a_reg.dec_kind == rqt_pkg::QCLASS_GOOD)
            begin
                e = a_reg.dec_pos;
            end
            else
            begin
                bad = 1'b1;
            end
        end

        r_next.trimmed_length = e;
        r_next.adapter_cut    = a_reg.o;
        r_next.quality_cut    = a_reg.cut_pos - e;
        r_next.keep           = e >= cfg.min_length;
        r_next.status         = rqt_pkg::STATUS_OK;
        if (a_reg.too_long || bad)
        begin
            r_next.trimmed_length = '0;
            r_next.adapter_cut    = '0;
            r_next.quality_cut    = '0;
            r_next.keep           = 1'b0;
            r_next.status         = a_reg.too_long ? rqt_pkg::STATUS_TOO_LONG
                                                   : rqt_pkg::STATUS_BAD_QUALITY;
        end
    end

endmodule

FILE: hw/rtl/read_adapter_quality_trimmer.sv
// Top level of the read adapter and quality trimmer.
// The block takes one item per clock unless stalled: an adapter write or one read
// base with its quality byte. Every base within the maximum read length updates
// all 64 adapter mismatch counters and the 64-entry quality window in the same
// cycle, so unstalled bases stream at one per cycle with no gap between reads.
// The item flagged last is captured in the input register; its read then moves
// through the read snapshot, adapter hit selection and quality scan into the
// result register. The result register, the two end-of-read registers and the
// input register hold up to four finished reads while the result side stalls;
// the input side stalls only when a last base waits in the input register
// behind three full stages. No clearing pass runs after reset. The user writes
// configuration over the APB port only while no read is in flight; unenforced.
`include "assert_macros.svh"

module read_adapter_quality_trimmer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  rqt_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output rqt_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rqt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    rqt_pkg::cfg_t cfg;
    rqt_pkg::job_t job;
    logic          job_valid;
    logic          job_stall;
    logic          out_blocked;
    logic          res_failed;
    logic          res_empty;

    rqt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rqt_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg        (cfg),
        .job_valid  (job_valid),
        .job        (job),
        .job_stall  (job_stall)
    );

    rqt_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .job          (job),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign out_blocked = result_valid && result_stall;
    assign res_failed  = result_valid && result.status != rqt_pkg::STATUS_OK;
    assign res_empty   = result.trimmed_length == '0 && result.adapter_cut == '0
                         && result.quality_cut == '0 && !result.keep;

    // Input back-pressure can only come from a blocked result channel.
    `ASSERT_IMPLIES(a_stall_source, clk, rst_n, item_stall, out_blocked, "input stall, output free")

    // A failed read carries no lengths and is never kept.
    `ASSERT_IMPLIES(a_fail_zero, clk, rst_n, res_failed, res_empty, "failed read with nonzero fields")

    // A kept read meets the minimum length.
    `ASSERT_IMPLIES(a_keep_len, clk, rst_n, result_valid && result.keep, result.trimmed_length >= cfg.min_length, "kept read too short")

    // A pending snapshot stalls only while the output is blocked.
    `ASSERT_IMPLIES(a_job_stall, clk, rst_n, job_stall, out_blocked, "snapshot stall, output free")

endmodule
